/* hdl/mi4_pkg.sv */
// ----------------------------------------------------------------------------
// mi4_pkg
// Shared types, constants and address helpers for the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package mi4_pkg;

    localparam int FRACTION_BITS_DEF = 8;
    localparam int ELEM_W            = 16;
    localparam int COF_W             = 43;
    localparam int DET_W             = 61;
    localparam int QUO_BITS          = 18;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_RA,
        ST_T_RB,
        ST_T_RC,
        ST_T_M2,
        ST_T_ACC,
        ST_COF_WR,
        ST_DET_RD,
        ST_DET_MUL,
        ST_DET_ACC,
        ST_OUT_RD,
        ST_OUT_CHK,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR,
        OP_LATCH_A,
        OP_MUL1,
        OP_MUL2,
        OP_ACC,
        OP_COF_WR,
        OP_DMUL,
        OP_DACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       load_en;
        logic [3:0] wr_addr;
        logic [3:0] rd_addr;
        logic [3:0] cof_addr;
        logic       neg;
    } t_dp_cmd;

    typedef struct packed {
        logic det_zero;
    } t_dp_stat;

    // Column of the 3x3 minor used by factor s of term t.
    function automatic logic [1:0] minor_col(logic [2:0] t, logic [1:0] s);
        logic [1:0] col;
        col = 2'd0;
        case (t)
            3'd0: col = s;
            3'd1: col = (s == 2'd0) ? 2'd0 : ((s == 2'd1) ? 2'd2 : 2'd1);
            3'd2: col = (s == 2'd0) ? 2'd1 : ((s == 2'd1) ? 2'd0 : 2'd2);
            3'd3: col = (s == 2'd0) ? 2'd1 : ((s == 2'd1) ? 2'd2 : 2'd0);
            3'd4: col = (s == 2'd0) ? 2'd2 : ((s == 2'd1) ? 2'd0 : 2'd1);
            3'd5: col = (s == 2'd0) ? 2'd2 : ((s == 2'd1) ? 2'd1 : 2'd0);
            default: col = 2'd0;
        endcase
        return col;
    endfunction

    // Matrix address of factor s of term t in the minor of element k.
    function automatic logic [3:0] elem_addr(logic [3:0] k, logic [2:0] t, logic [1:0] s);
        logic [1:0] mc;
        logic [1:0] row;
        logic [1:0] col;
        mc  = minor_col(t, s);
        row = (s >= k[3:2]) ? s + 2'd1 : s;
        col = (mc >= k[1:0]) ? mc + 2'd1 : mc;
        return {row, col};
    endfunction

    function automatic logic term_neg(logic [2:0] t);
        return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

endpackage

/* hdl/mi4_ctrl.sv */
// ----------------------------------------------------------------------------
// mi4_ctrl
// Sequencer: loads elements, steps cofactor terms, determinant and divides.
// ----------------------------------------------------------------------------
module mi4_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  mi4_pkg::t_dp_stat  i_stat,
    output mi4_pkg::t_dp_cmd   o_cmd
);

    mi4_pkg::t_state r_state, n_state;
    logic [3:0] r_k, n_k;
    logic [2:0] r_t, n_t;
    logic [4:0] r_d, n_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mi4_pkg::ST_IDLE;
            r_k     <= 4'd0;
            r_t     <= 3'd0;
            r_d     <= 5'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_t     <= n_t;
            r_d     <= n_d;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_t     = r_t;
        n_d     = r_d;
        case (r_state)
            mi4_pkg::ST_IDLE: begin
                if (start) begin
                    if (r_k == 4'd15) begin
                        n_state = mi4_pkg::ST_T_RA;
                        n_k     = 4'd0;
                        n_t     = 3'd0;
                    end else begin
                        n_k = r_k + 4'd1;
                    end
                end
            end
            mi4_pkg::ST_T_RA:  n_state = mi4_pkg::ST_T_RB;
            mi4_pkg::ST_T_RB:  n_state = mi4_pkg::ST_T_RC;
            mi4_pkg::ST_T_RC:  n_state = mi4_pkg::ST_T_M2;
            mi4_pkg::ST_T_M2:  n_state = mi4_pkg::ST_T_ACC;
            mi4_pkg::ST_T_ACC: begin
                if (r_t == 3'd5) begin
                    n_t     = 3'd0;
                    n_state = mi4_pkg::ST_COF_WR;
                end else begin
                    n_t     = r_t + 3'd1;
                    n_state = mi4_pkg::ST_T_RA;
                end
            end
            mi4_pkg::ST_COF_WR: begin
                if (r_k == 4'd15) begin
                    n_k     = 4'd0;
                    n_state = mi4_pkg::ST_DET_RD;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = mi4_pkg::ST_T_RA;
                end
            end
            mi4_pkg::ST_DET_RD:  n_state = mi4_pkg::ST_DET_MUL;
            mi4_pkg::ST_DET_MUL: n_state = mi4_pkg::ST_DET_ACC;
            mi4_pkg::ST_DET_ACC: begin
                if (r_k == 4'd3) begin
                    n_k     = 4'd0;
                    n_state = mi4_pkg::ST_OUT_RD;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = mi4_pkg::ST_DET_RD;
                end
            end
            mi4_pkg::ST_OUT_RD: n_state = mi4_pkg::ST_OUT_CHK;
            mi4_pkg::ST_OUT_CHK: begin
                if (i_stat.det_zero) begin
                    n_state = mi4_pkg::ST_EMIT;
                end else begin
                    n_d     = 5'd0;
                    n_state = mi4_pkg::ST_DIV;
                end
            end
            mi4_pkg::ST_DIV: begin
                if (r_d == 5'(mi4_pkg::QUO_BITS - 1)) begin
                    n_state = mi4_pkg::ST_EMIT;
                end else begin
                    n_d = r_d + 5'd1;
                end
            end
            mi4_pkg::ST_EMIT: begin
                if (r_k == 4'd15) begin
                    n_k     = 4'd0;
                    n_state = mi4_pkg::ST_IDLE;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = mi4_pkg::ST_OUT_RD;
                end
            end
            default: n_state = mi4_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = mi4_pkg::OP_NOP;
        o_cmd.wr_addr  = r_k;
        o_cmd.rd_addr  = r_k;
        o_cmd.cof_addr = r_k;
        busy           = (r_state != mi4_pkg::ST_IDLE);
        case (r_state)
            mi4_pkg::ST_IDLE: begin
                o_cmd.op      = mi4_pkg::OP_CLR;
                o_cmd.load_en = start;
            end
            mi4_pkg::ST_T_RA: begin
                o_cmd.rd_addr = mi4_pkg::elem_addr(r_k, r_t, 2'd0);
            end
            mi4_pkg::ST_T_RB: begin
                o_cmd.rd_addr = mi4_pkg::elem_addr(r_k, r_t, 2'd1);
                o_cmd.op      = mi4_pkg::OP_LATCH_A;
            end
            mi4_pkg::ST_T_RC: begin
                o_cmd.rd_addr = mi4_pkg::elem_addr(r_k, r_t, 2'd2);
                o_cmd.op      = mi4_pkg::OP_MUL1;
            end
            mi4_pkg::ST_T_M2: o_cmd.op = mi4_pkg::OP_MUL2;
            mi4_pkg::ST_T_ACC: begin
                o_cmd.op  = mi4_pkg::OP_ACC;
                o_cmd.neg = mi4_pkg::term_neg(r_t) ^ r_k[2] ^ r_k[0];
            end
            mi4_pkg::ST_COF_WR: begin
                o_cmd.op       = mi4_pkg::OP_COF_WR;
                o_cmd.cof_addr = {r_k[1:0], r_k[3:2]};
            end
            mi4_pkg::ST_DET_RD: begin
                o_cmd.rd_addr  = {2'b00, r_k[1:0]};
                o_cmd.cof_addr = {r_k[1:0], 2'b00};
            end
            mi4_pkg::ST_DET_MUL: o_cmd.op = mi4_pkg::OP_DMUL;
            mi4_pkg::ST_DET_ACC: o_cmd.op = mi4_pkg::OP_DACC;
            mi4_pkg::ST_OUT_RD:  o_cmd.op = mi4_pkg::OP_NOP;
            mi4_pkg::ST_OUT_CHK: begin
                o_cmd.op = i_stat.det_zero ? mi4_pkg::OP_NOP : mi4_pkg::OP_DIV_INIT;
            end
            mi4_pkg::ST_DIV:  o_cmd.op = mi4_pkg::OP_DIV_STEP;
            mi4_pkg::ST_EMIT: o_cmd.op = mi4_pkg::OP_EMIT;
            default: o_cmd.op = mi4_pkg::OP_NOP;
        endcase
    end

endmodule

/* hdl/mi4_dp.sv */
// ----------------------------------------------------------------------------
// mi4_dp
// Datapath: element and cofactor stores, multipliers, serial divider.
// ----------------------------------------------------------------------------
module mi4_dp #(
    parameter int FRACTION_BITS = mi4_pkg::FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [15:0]        i_element_value,
    input  mi4_pkg::t_dp_cmd          i_cmd,
    output mi4_pkg::t_dp_stat         o_stat,
    output logic                      o_strobe,
    output logic signed [15:0]        o_inverse_value,
    output logic [3:0]                o_element_index,
    output logic                      o_singular,
    output logic                      o_saturated,
    output logic                      o_last_of_run
);

    localparam int ACC_W  = 49;
    localparam int LSH    = (3 * FRACTION_BITS < 16) ? 16 - 3 * FRACTION_BITS : 0;
    localparam int RSH    = (3 * FRACTION_BITS > 16) ? 3 * FRACTION_BITS - 16 : 0;
    localparam int SW     = ACC_W + LSH;
    localparam int NW     = mi4_pkg::COF_W + 2 * FRACTION_BITS;
    localparam int QB     = mi4_pkg::QUO_BITS;
    localparam int DSH_W  = mi4_pkg::DET_W + QB - 1;
    localparam int RW     = (NW > DSH_W) ? NW : DSH_W;

    logic signed [15:0]               r_mem [16];
    logic signed [mi4_pkg::COF_W-1:0] r_cof_mem [16];

    logic signed [15:0]               r_rd;
    logic signed [mi4_pkg::COF_W-1:0] r_cof;
    logic signed [15:0]               r_opa;
    logic signed [31:0]               r_p1;
    logic signed [47:0]               r_p2;
    logic signed [ACC_W-1:0]          r_acc;
    logic signed [58:0]               r_dp;
    logic signed [mi4_pkg::DET_W-1:0] r_det;
    logic [RW-1:0]                    r_rem;
    logic [RW-1:0]                    r_dsh;
    logic [QB-1:0]                    r_q;
    logic                             r_neg;

    logic                             r_strobe;
    logic signed [15:0]               r_val;
    logic [3:0]                       r_idx;
    logic                             r_sing;
    logic                             r_sat;
    logic                             r_last;

    logic signed [ACC_W-1:0]          p2_ext;
    logic signed [SW-1:0]             cof_sh;
    logic signed [mi4_pkg::COF_W-1:0] cof_val;
    logic signed [NW-1:0]             num;
    logic [NW-1:0]                    mag_n;
    logic [mi4_pkg::DET_W-1:0]        mag_d;
    logic                             det_zero;
    logic signed [15:0]               e_val;
    logic                             e_sat;

    assign det_zero = (r_det == '0);
    assign p2_ext   = ACC_W'(r_p2);
    assign cof_sh   = (SW'(r_acc) <<< LSH) >>> RSH;
    assign num      = NW'(r_cof) <<< (2 * FRACTION_BITS);
    assign mag_n    = num[NW-1] ? NW'(-num) : NW'(num);
    assign mag_d    = r_det[mi4_pkg::DET_W-1] ? mi4_pkg::DET_W'(-r_det)
                                              : mi4_pkg::DET_W'(r_det);

    always_comb begin
        if (cof_sh[SW-1:mi4_pkg::COF_W-1] == '0
            || cof_sh[SW-1:mi4_pkg::COF_W-1] == '1) begin
            cof_val = cof_sh[mi4_pkg::COF_W-1:0];
        end else if (cof_sh[SW-1]) begin
            cof_val = {1'b1, {(mi4_pkg::COF_W-1){1'b0}}};
        end else begin
            cof_val = {1'b0, {(mi4_pkg::COF_W-1){1'b1}}};
        end
    end

    always_comb begin
        e_sat = 1'b0;
        e_val = r_q[15:0];
        if (det_zero) begin
            e_val = r_rd;
        end else if (!r_neg) begin
            if (r_q > QB'(32767)) begin
                e_val = 16'sh7FFF;
                e_sat = 1'b1;
            end
        end else begin
            if (r_q > QB'(32768)) begin
                e_val = 16'sh8000;
                e_sat = 1'b1;
            end else begin
                e_val = -r_q[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_mem[i_cmd.wr_addr] <= i_element_value;
        end
        r_rd <= r_mem[i_cmd.rd_addr];
        if (i_cmd.op == mi4_pkg::OP_COF_WR) begin
            r_cof_mem[i_cmd.cof_addr] <= cof_val;
        end
        r_cof <= r_cof_mem[i_cmd.cof_addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mi4_pkg::OP_CLR: begin
                r_acc <= '0;
                r_det <= '0;
            end
            mi4_pkg::OP_LATCH_A: r_opa <= r_rd;
            mi4_pkg::OP_MUL1:    r_p1  <= r_opa * r_rd;
            mi4_pkg::OP_MUL2:    r_p2  <= r_p1 * r_rd;
            mi4_pkg::OP_ACC:     r_acc <= i_cmd.neg ? r_acc - p2_ext : r_acc + p2_ext;
            mi4_pkg::OP_COF_WR:  r_acc <= '0;
            mi4_pkg::OP_DMUL:    r_dp  <= r_rd * r_cof;
            mi4_pkg::OP_DACC:    r_det <= r_det + mi4_pkg::DET_W'(r_dp);
            mi4_pkg::OP_DIV_INIT: begin
                r_rem <= RW'(mag_n);
                r_dsh <= RW'(mag_d) << (QB - 1);
                r_neg <= num[NW-1] ^ r_det[mi4_pkg::DET_W-1];
                r_q   <= '0;
            end
            mi4_pkg::OP_DIV_STEP: begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[QB-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[QB-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == mi4_pkg::OP_EMIT);
        end
        if (i_cmd.op == mi4_pkg::OP_EMIT) begin
            r_val  <= e_val;
            r_idx  <= i_cmd.rd_addr;
            r_sing <= det_zero;
            r_sat  <= e_sat;
            r_last <= (i_cmd.rd_addr == 4'd15);
        end
    end

    assign o_stat.det_zero = det_zero;
    assign o_strobe        = r_strobe;
    assign o_inverse_value = r_val;
    assign o_element_index = r_idx;
    assign o_singular      = r_sing;
    assign o_saturated     = r_sat;
    assign o_last_of_run   = r_last;

endmodule

/* hdl/matrix_inverse_4x4.sv */
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 fixed-point matrix inverse by cofactors and adjugate.
// ----------------------------------------------------------------------------
// Elements load one per cycle while busy is low. The sixteenth starts the
// computation: 96 triple products, each read, multiplied and accumulated,
// plus 16 cofactor writes, then the determinant from the first row, then
// per result a read, a zero check and a serial divide that yields 18
// quotient bits, or no divide for a singular matrix. No new elements are
// taken until the last result has been emitted.
// Results leave on o_strobe for one cycle each and cannot be held off.
module matrix_inverse_4x4 #(
    parameter int FRACTION_BITS = mi4_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_element_value,
    output logic               o_strobe,
    output logic signed [15:0] o_inverse_value,
    output logic [3:0]         o_element_index,
    output logic               o_singular,
    output logic               o_saturated,
    output logic               o_last_of_run
);

    mi4_pkg::t_dp_cmd  cmd;
    mi4_pkg::t_dp_stat stat;

    mi4_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mi4_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_element_value (i_element_value),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_strobe        (o_strobe),
        .o_inverse_value (o_inverse_value),
        .o_element_index (o_element_index),
        .o_singular      (o_singular),
        .o_saturated     (o_saturated),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

/* tb/matrix_inverse_4x4_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_tb
// Feeds 4x4 Q8.8 matrices element by element (directed corner matrices, then
// random well-formed, singular, diagonal and saturating ones) and checks each
// inverse element against an in-bench cofactor/adjugate inverse computation.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_tb;

    localparam int FB = mi4_pkg::FRACTION_BITS_DEF;
    localparam int CSH = 3 * FB - 16;
    localparam longint CMAX = (longint'(1) << 42) - 1;
    localparam longint CMIN = -(longint'(1) << 42);
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct {
        logic signed [15:0] inv;
        logic [3:0]         idx;
        logic               sing;
        logic               sat;
        logic               last;
    } t_inv_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [15:0] i_element_value = '0;
    logic busy, o_strobe, o_singular, o_saturated, o_last_of_run;
    logic signed [15:0] o_inverse_value;
    logic [3:0] o_element_index;

    matrix_inverse_4x4 DUT (.*);

    always #2 i_clk = ~i_clk;

    logic signed [15:0] pending_elems[$];
    t_inv_item expected_inv[$];
    longint elem_buf[16];
    int load_pos = 0;
    int errors = 0;
    int matrices = 0, singulars = 0, sats = 0;
    int send_idle_pct = 31;
    longint cycles = 0;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("tb: mismatch %s got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic longint minor_of(int r, int c);
        int rows[3], cols[3];
        int n;
        longint m[3][3];
        n = 0;
        for (int k = 0; k < 4; k++) if (k != r) rows[n++] = k;
        n = 0;
        for (int k = 0; k < 4; k++) if (k != c) cols[n++] = k;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m[i][j] = elem_buf[rows[i] * 4 + cols[j]];
        return m[0][0]*m[1][1]*m[2][2] - m[0][0]*m[1][2]*m[2][1]
             - m[0][1]*m[1][0]*m[2][2] + m[0][1]*m[1][2]*m[2][0]
             + m[0][2]*m[1][0]*m[2][1] - m[0][2]*m[1][1]*m[2][0];
    endfunction

    task automatic predict_inverse(logic signed [15:0] v);
        longint cof[16];
        longint s, det, q;
        t_inv_item it;
        elem_buf[load_pos] = v;
        if (load_pos < 15) begin
            load_pos++;
            return;
        end
        load_pos = 0;
        matrices++;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                s = minor_of(r, c);
                if ((r + c) & 1) s = -s;
                if (CSH > 0) s = s >>> CSH;
                else if (CSH < 0) s = s <<< (-CSH);
                if (s > CMAX) s = CMAX;
                if (s < CMIN) s = CMIN;
                cof[c * 4 + r] = s;
            end
        det = 0;
        for (int j = 0; j < 4; j++) det += elem_buf[j] * cof[j * 4];
        if (det == 0) singulars++;
        for (int i = 0; i < 16; i++) begin
            it.sing = (det == 0);
            it.sat = 1'b0;
            if (det == 0) q = elem_buf[i];
            else begin
                q = (cof[i] <<< (2 * FB)) / det;
                if (q > 32767) begin q = 32767; it.sat = 1'b1; end
                if (q < -32768) begin q = -32768; it.sat = 1'b1; end
            end
            if (it.sat) sats++;
            it.inv = q[15:0];
            it.idx = i[3:0];
            it.last = (i == 15);
            expected_inv.push_back(it);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) predict_inverse(i_element_value);
            if (start && busy) begin
            end else if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                start <= 1'b1;
                i_element_value <= pending_elems.pop_front();
            end else begin
                start <= 1'b0;
                i_element_value <= 16'($urandom);
            end
        end
    end

    always @(posedge i_clk) begin
        t_inv_item e;
        cycles++;
        if (i_rst_n && o_strobe) begin
            if (expected_inv.size() == 0) report_mismatch("unexpected result", 1, 0);
            else begin
                e = expected_inv.pop_front();
                if (o_inverse_value !== e.inv) report_mismatch("inverse_value", o_inverse_value, e.inv);
                if (o_element_index !== e.idx) report_mismatch("element_index", o_element_index, e.idx);
                if (o_singular !== e.sing) report_mismatch("singular", o_singular, e.sing);
                if (o_saturated !== e.sat) report_mismatch("saturated", o_saturated, e.sat);
                if (o_last_of_run !== e.last) report_mismatch("last_of_run", o_last_of_run, e.last);
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_matrix(int kind);
        logic signed [15:0] v;
        logic signed [15:0] row0[4];
        for (int i = 0; i < 16; i++) begin
            case (kind)
                0: v = 16'($urandom);
                1: v = 16'($urandom_range(1023)) - 16'sd512;
                2: v = (i % 5 == 0) ? 16'($urandom_range(1023)) - 16'sd512 : 16'sd0;
                3: v = (i % 5 == 0) ? 16'($urandom_range(15)) - 16'sd8
                                    : 16'($urandom_range(3)) - 16'sd1;
                4: v = (i < 4) ? 16'($urandom_range(511)) - 16'sd256 : row0[i % 4];
                default: v = 16'($urandom_range(65535));
            endcase
            if (i < 4) row0[i] = v;
            pending_elems.push_back(v);
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) pending_elems.push_back((i % 5 == 0) ? 16'sh0100 : 16'sh0);
        for (int i = 0; i < 16; i++) pending_elems.push_back((i % 5 == 0) ? 16'sh7fff : 16'sh0);
        for (int i = 0; i < 16; i++) pending_elems.push_back((i % 5 == 0) ? 16'sh8000 : 16'sh0);
        for (int i = 0; i < 16; i++) pending_elems.push_back((i % 5 == 0) ? 16'sh0001 : 16'sh0);
        for (int i = 0; i < 16; i++) pending_elems.push_back(16'sh0);
        for (int i = 0; i < 16; i++) pending_elems.push_back(i[0] ? 16'sh7fff : 16'sh8000);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < 14; k++) add_matrix(k % 5);
        wait (pending_elems.size() == 0);
        send_idle_pct = 78;
        for (int k = 0; k < 3; k++) add_matrix(k);
        wait (pending_elems.size() == 0);
        send_idle_pct = 0;
        for (int k = 0; k < 3; k++) add_matrix(k + 1);
        wait (pending_elems.size() == 0);
        @(posedge i_clk);
        while (start || busy || expected_inv.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("tb: %0d matrices inverted, %0d singular, %0d saturated elements",
                 matrices, singulars, sats);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
